@@ hdl/hce_pkg.sv @@
package hce_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF = 64;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned NWGT_W = 22;
  localparam int unsigned CODE_W = 63;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned NUM_SYM_CODES = 256;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_ENCODE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_NO_TABLE = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic enc_capture;
    logic out_enc;
    logic out_ok;
    logic build_init;
    logic scan_start;
    logic merge;
    logic walk_init;
    logic pop;
    logic popw;
    logic leaf_wr;
    logic push_r;
    logic push_l;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
    logic scan_done;
    logic tree_done;
    logic leaf_node;
    logic stack_empty;
  } sts_t;

endpackage

@@ hdl/hce_if.sv @@
interface hce_in_if import hce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [SYM_W-1:0] symbol;
  logic [WGT_W-1:0] weight;
  logic             last_entry;

  modport source (output valid, req_type, symbol, weight, last_entry, input ready);
  modport sink   (input valid, req_type, symbol, weight, last_entry, output ready);
endinterface

interface hce_out_if import hce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic [STAT_W-1:0] status;

  modport source (output valid, code_bits, code_length, status, input ready);
  modport sink   (input valid, code_bits, code_length, status, output ready);
endinterface

@@ hdl/hce_ram.sv @@
module hce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/hce_datapath.sv @@
module hce_datapath import hce_pkg::*; #(
  parameter int unsigned MaxSymbols = MAX_SYMBOLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic [WGT_W-1:0]  weight_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] out_bits_o,
  output logic [LEN_W-1:0]  out_len_o,
  output status_e           out_status_o
);

  localparam int unsigned NodeCnt = 2 * MaxSymbols - 1;
  localparam int unsigned NW      = $clog2(NodeCnt);
  localparam int unsigned LW      = $clog2(MaxSymbols);
  localparam int unsigned CW      = $clog2(MaxSymbols + 1);
  localparam int unsigned StkW    = NW + CODE_W + LEN_W;
  localparam int unsigned CodeW   = CODE_W + LEN_W;

  logic [CW-1:0]            count_q;
  logic                     ready_q;
  logic [NUM_SYM_CODES-1:0] present_q;
  logic [NodeCnt-1:0]       live_q;
  logic [NW-1:0]            total_q, scan_q, pidx_q, best_q, sec_q;
  logic                     scanning_q, pend_q, bfound_q, sfound_q;
  logic [NWGT_W-1:0]        bw_q, sw_q;
  logic [CW-1:0]            sp_q;
  logic [CODE_W-1:0]        cur_bits_q;
  logic [LEN_W-1:0]         cur_len_q;
  logic [NW-1:0]            left_q;
  status_e                  enc_status_q;
  logic                     out_valid_q;
  logic [CODE_W-1:0]        out_bits_q;
  logic [LEN_W-1:0]         out_len_q;
  status_e                  out_status_q;

  logic [CW-1:0]     cnt_eff;
  logic              store;
  logic [NW-1:0]     n_node, node_end, root;
  logic [NW:0]       dbl;
  logic [NWGT_W-1:0] node_rdata, node_wdata, sum;
  logic [NW-1:0]     node_waddr;
  logic              node_we;
  logic [SYM_W-1:0]  leaf_rdata;
  logic [2*NW-1:0]   child_rdata;
  logic [StkW-1:0]   stk_rdata, stk_wdata;
  logic              stk_we;
  logic [LW-1:0]     stk_waddr;
  logic [NW-1:0]     stk_node;
  logic [CODE_W-1:0] stk_bits;
  logic [LEN_W-1:0]  stk_len;
  logic [CodeW-1:0]  code_rdata;

  assign cnt_eff  = ready_q ? '0 : count_q;
  assign store    = cnt_eff < CW'(MaxSymbols);
  assign n_node   = NW'(count_q);
  assign dbl      = {n_node, 1'b0};
  assign node_end = NW'(dbl - (NW + 1)'(1));
  assign root     = node_end - NW'(1);
  assign sum      = NWGT_W'(bw_q + sw_q);

  assign {stk_node, stk_bits, stk_len} = stk_rdata;

  assign node_we    = (cmd_i.load && store) || cmd_i.merge;
  assign node_waddr = cmd_i.merge ? total_q : NW'(cnt_eff);
  assign node_wdata = cmd_i.merge ? sum : NWGT_W'(weight_i);

  hce_ram #(.Width(NWGT_W), .Depth(NodeCnt)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(scan_q), .rdata_o(node_rdata)
  );

  hce_ram #(.Width(SYM_W), .Depth(MaxSymbols)) u_leaf_ram (
    .clk_i, .we_i(cmd_i.load && store), .waddr_i(cnt_eff[LW-1:0]), .wdata_i(symbol_i),
    .raddr_i(stk_node[LW-1:0]), .rdata_o(leaf_rdata)
  );

  // One spare entry keeps the address width equal to the leaf index width.
  hce_ram #(.Width(2 * NW), .Depth(MaxSymbols)) u_child_ram (
    .clk_i, .we_i(cmd_i.merge), .waddr_i(LW'(total_q - n_node)),
    .wdata_i({best_q, sec_q}),
    .raddr_i(LW'(stk_node - n_node)), .rdata_o(child_rdata)
  );

  always_comb begin
    stk_we    = cmd_i.walk_init || cmd_i.push_r || cmd_i.push_l;
    stk_waddr = cmd_i.walk_init ? '0 : sp_q[LW-1:0];
    if (cmd_i.walk_init) begin
      stk_wdata = {root, {CODE_W{1'b0}}, {LEN_W{1'b0}}};
    end else if (cmd_i.push_r) begin
      stk_wdata = {child_rdata[NW-1:0], {cur_bits_q[CODE_W-2:0], 1'b1}, cur_len_q + LEN_W'(1)};
    end else begin
      stk_wdata = {left_q, {cur_bits_q[CODE_W-2:0], 1'b0}, cur_len_q + LEN_W'(1)};
    end
  end

  hce_ram #(.Width(StkW), .Depth(MaxSymbols)) u_stack_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(LW'(sp_q - CW'(1))), .rdata_o(stk_rdata)
  );

  hce_ram #(.Width(CodeW), .Depth(NUM_SYM_CODES)) u_code_ram (
    .clk_i, .we_i(cmd_i.leaf_wr), .waddr_i(leaf_rdata), .wdata_i({cur_bits_q, cur_len_q}),
    .raddr_i(symbol_i), .rdata_o(code_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ready_q     <= 1'b0;
      present_q   <= '0;
      scanning_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ready_q <= 1'b0;
        if (ready_q) begin
          present_q <= '0;
        end
        count_q <= store ? cnt_eff + CW'(1) : cnt_eff;
      end
      if (cmd_i.leaf_wr) begin
        present_q[leaf_rdata] <= 1'b1;
      end
      if (cmd_i.out_ok) begin
        ready_q <= 1'b1;
      end

      if (cmd_i.scan_start) begin
        scanning_q <= 1'b1;
        pend_q     <= 1'b0;
      end else if (scanning_q) begin
        if (scan_q != total_q) begin
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
          if (!pend_q) begin
            scanning_q <= 1'b0;
          end
        end
      end

      if (cmd_i.out_enc || cmd_i.out_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      total_q <= n_node;
      for (int i = 0; i < NodeCnt; i++) begin
        live_q[i] <= NW'(i) < n_node;
      end
    end
    if (cmd_i.scan_start) begin
      scan_q   <= '0;
      bfound_q <= 1'b0;
      sfound_q <= 1'b0;
    end else if (scanning_q && scan_q != total_q) begin
      pidx_q <= scan_q;
      scan_q <= scan_q + NW'(1);
    end
    // Strict compares keep the earliest node among equal weights.
    if (pend_q && live_q[pidx_q]) begin
      if (!bfound_q || node_rdata < bw_q) begin
        sec_q    <= best_q;
        sw_q     <= bw_q;
        sfound_q <= bfound_q;
        best_q   <= pidx_q;
        bw_q     <= node_rdata;
        bfound_q <= 1'b1;
      end else if (!sfound_q || node_rdata < sw_q) begin
        sec_q    <= pidx_q;
        sw_q     <= node_rdata;
        sfound_q <= 1'b1;
      end
    end
    if (cmd_i.merge) begin
      live_q[best_q]  <= 1'b0;
      live_q[sec_q]   <= 1'b0;
      live_q[total_q] <= 1'b1;
      total_q         <= total_q + NW'(1);
    end

    if (cmd_i.walk_init) begin
      sp_q <= CW'(1);
    end else if (cmd_i.pop) begin
      sp_q <= sp_q - CW'(1);
    end else if (cmd_i.push_r || cmd_i.push_l) begin
      sp_q <= sp_q + CW'(1);
    end
    if (cmd_i.popw) begin
      cur_bits_q <= stk_bits;
      cur_len_q  <= stk_len;
    end
    if (cmd_i.push_r) begin
      left_q <= child_rdata[2*NW-1:NW];
    end

    if (cmd_i.enc_capture) begin
      if (!ready_q) begin
        enc_status_q <= ST_NO_TABLE;
      end else if (!present_q[symbol_i]) begin
        enc_status_q <= ST_UNKNOWN;
      end else begin
        enc_status_q <= ST_OK;
      end
    end
    if (cmd_i.out_enc) begin
      out_status_q <= enc_status_q;
      out_bits_q   <= (enc_status_q == ST_OK) ? code_rdata[CodeW-1:LEN_W] : '0;
      out_len_q    <= (enc_status_q == ST_OK) ? code_rdata[LEN_W-1:0] : '0;
    end else if (cmd_i.out_ok) begin
      out_status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
      out_bits_q   <= '0;
      out_len_q    <= '0;
    end
  end

  assign sts_o.out_busy    = out_valid_q;
  assign sts_o.scan_done   = scanning_q && (scan_q == total_q) && !pend_q;
  assign sts_o.tree_done   = total_q == node_end;
  assign sts_o.leaf_node   = stk_node < n_node;
  assign sts_o.stack_empty = sp_q == '0;

  assign out_valid_o  = out_valid_q;
  assign out_bits_o   = out_bits_q;
  assign out_len_o    = out_len_q;
  assign out_status_o = out_status_q;

endmodule

@@ hdl/hce_ctrl.sv @@
module hce_ctrl import hce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_req_type_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ENC, S_BINIT, S_BNEXT, S_SCAN, S_MERGE,
    S_WINIT, S_POP, S_POPW, S_LEAF, S_CHILD, S_PUSHL
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && !sts_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = accept && (in_req_type_i == REQ_LOAD);
    cmd_o.enc_capture = accept && (in_req_type_i == REQ_ENCODE);
    cmd_o.out_enc     = state_q == S_ENC;
    cmd_o.build_init  = state_q == S_BINIT;
    cmd_o.scan_start  = (state_q == S_BNEXT) && !sts_i.tree_done;
    cmd_o.merge       = state_q == S_MERGE;
    cmd_o.walk_init   = state_q == S_WINIT;
    cmd_o.out_ok      = (state_q == S_POP) && sts_i.stack_empty;
    cmd_o.pop         = (state_q == S_POP) && !sts_i.stack_empty;
    cmd_o.popw        = state_q == S_POPW;
    cmd_o.leaf_wr     = state_q == S_LEAF;
    cmd_o.push_r      = state_q == S_CHILD;
    cmd_o.push_l      = state_q == S_PUSHL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type_i == REQ_ENCODE) begin
              state_q <= S_ENC;
            end else if (in_last_i) begin
              state_q <= S_BINIT;
            end
          end
        end
        S_ENC:   state_q <= S_IDLE;
        S_BINIT: state_q <= S_BNEXT;
        S_BNEXT: state_q <= sts_i.tree_done ? S_WINIT : S_SCAN;
        S_SCAN:  if (sts_i.scan_done) state_q <= S_MERGE;
        S_MERGE: state_q <= S_BNEXT;
        S_WINIT: state_q <= S_POP;
        S_POP:   state_q <= sts_i.stack_empty ? S_IDLE : S_POPW;
        S_POPW:  state_q <= sts_i.leaf_node ? S_LEAF : S_CHILD;
        S_LEAF:  state_q <= S_POP;
        S_CHILD: state_q <= S_PUSHL;
        S_PUSHL: state_q <= S_POP;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/huffman_code_build_and_encode_core.sv @@
// Huffman code table builder and encoder.
// req_i carries load and encode beats; res_o returns one result beat per
// encode and one per load marked last. A load without the last mark gives
// no result and leaves the block ready for the next beat.
// Encode: the code table RAM is read at the accept edge and the result beat is
// registered from it in state S_ENC; the next request waits until that beat
// is taken.
// Build: after the last load the block merges n leaves in n-1 passes; each
// pass scans every node made so far through the node weight RAM, one node a
// cycle, in the states S_BNEXT, S_SCAN and S_MERGE. The code walk then visits
// each of the 2n-1 nodes through the stack RAM, a leaf in S_POP, S_POPW and
// S_LEAF, an inner node in S_POP, S_POPW, S_CHILD and S_PUSHL.
// req_i.ready stays low during the build and code walk, during an encode and
// while a result beat waits. A stalled result beat holds its value until res_o.ready is seen.
// Reset clears the table-ready flag, the entry count, the presence bits, the
// result valid flag and the controller; the RAM contents need no clearing pass.
module huffman_code_build_and_encode_core import hce_pkg::*; #(
  parameter int unsigned MaxSymbols = MAX_SYMBOLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hce_in_if.sink    req_i,
  hce_out_if.source res_o
);

  cmd_t    cmd;
  sts_t    sts;
  status_e out_status;

  hce_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_i.valid), .in_req_type_i(req_i.req_type),
    .in_last_i(req_i.last_entry), .in_ready_o(req_i.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  hce_datapath #(.MaxSymbols(MaxSymbols)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .symbol_i(req_i.symbol), .weight_i(req_i.weight),
    .out_valid_o(res_o.valid), .out_ready_i(res_o.ready),
    .out_bits_o(res_o.code_bits), .out_len_o(res_o.code_length),
    .out_status_o(out_status)
  );

  assign res_o.status = out_status;

endmodule

@@ hdl/hce_checker.sv @@
module hce_checker import hce_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_req_type_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CODE_W-1:0] out_bits_i,
  input logic [LEN_W-1:0]  out_len_i,
  input logic [STAT_W-1:0] out_status_i
);

  // A waiting result beat must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bits_i)
      && $stable(out_len_i) && $stable(out_status_i))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while a result waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_req_type_i == REQ_ENCODE) |=> ##1 out_valid_i)
    else $error("encode result not on time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_req_type_i == REQ_LOAD) && !in_last_i
      |=> !out_valid_i && in_ready_i)
    else $error("plain load produced a result or stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> (out_bits_i == '0) && (out_len_i == '0))
    else $error("error result carries a code");

endmodule

bind huffman_code_build_and_encode_core hce_checker u_hce_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(req_i.valid), .in_ready_i(req_i.ready),
  .in_req_type_i(req_i.req_type), .in_last_i(req_i.last_entry),
  .out_valid_i(res_o.valid), .out_ready_i(res_o.ready),
  .out_bits_i(res_o.code_bits), .out_len_i(res_o.code_length),
  .out_status_i(res_o.status)
);

@@ tb/hce_checker.sv @@
module hce_scoreboard import hce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  hce_in_if    req_i,
  hce_out_if   res_i,
  output int   errors_o,
  output int   pending_o
);

  localparam int MaxSym   = MAX_SYMBOLS_DEF;
  localparam int MaxNodes = 2 * MaxSym - 1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    status_e           status;
  } code_res_t;

  logic [SYM_W-1:0]  leaf_sym [MaxSym];
  logic [NWGT_W-1:0] node_wgt [MaxNodes];
  int                left_of  [MaxSym-1];
  int                right_of [MaxSym-1];
  logic [CODE_W-1:0] tab_code [NUM_SYM_CODES];
  logic [LEN_W-1:0]  tab_len  [NUM_SYM_CODES];
  bit                present  [NUM_SYM_CODES];
  int                n_loaded;
  bit                table_ok;
  code_res_t         code_q[$];

  // Merge the two lightest live nodes until one is left, then walk the tree
  // left side first and record each leaf's code.
  function automatic void build_codes();
    bit                live [MaxNodes];
    int                stk_node [MaxNodes];
    logic [63:0]       stk_bits [MaxNodes];
    int                stk_len  [MaxNodes];
    int                pick [2];
    int                n, total, sp, nd, ln, best;
    bit                found;
    logic [63:0]       bits;
    n = n_loaded;
    if (n == 0) return;
    for (int i = 0; i < MaxNodes; i++) live[i] = (i < n);
    total = n;
    while (total < 2 * n - 1) begin
      for (int j = 0; j < 2; j++) begin
        best = 0;
        found = 0;
        for (int i = 0; i < total; i++) begin
          if (live[i] && (!found || node_wgt[i] < node_wgt[best])) begin
            best = i;
            found = 1;
          end
        end
        live[best] = 0;
        pick[j] = best;
      end
      left_of[total-n] = pick[0];
      right_of[total-n] = pick[1];
      node_wgt[total] = NWGT_W'(node_wgt[pick[0]] + node_wgt[pick[1]]);
      live[total] = 1;
      total++;
    end
    stk_node[0] = total - 1;
    stk_bits[0] = '0;
    stk_len[0] = 0;
    sp = 1;
    while (sp > 0) begin
      sp--;
      nd = stk_node[sp];
      bits = stk_bits[sp];
      ln = stk_len[sp];
      if (nd < n) begin
        tab_code[leaf_sym[nd]] = bits[CODE_W-1:0];
        tab_len[leaf_sym[nd]] = ln[LEN_W-1:0];
        present[leaf_sym[nd]] = 1;
      end else if (sp + 2 <= MaxNodes && ln < 63) begin
        stk_node[sp] = right_of[nd-n];
        stk_bits[sp] = {bits[62:0], 1'b1};
        stk_len[sp] = ln + 1;
        sp++;
        stk_node[sp] = left_of[nd-n];
        stk_bits[sp] = {bits[62:0], 1'b0};
        stk_len[sp] = ln + 1;
        sp++;
      end
    end
    table_ok = 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    code_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SYM_CODES; i++) present[i] = 0;
      n_loaded = 0;
      table_ok = 0;
      errors_o = 0;
      pending_o = 0;
      code_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type == REQ_LOAD) begin
          if (table_ok) begin
            table_ok = 0;
            n_loaded = 0;
            for (int i = 0; i < NUM_SYM_CODES; i++) present[i] = 0;
          end
          if (n_loaded < MaxSym) begin
            leaf_sym[n_loaded] = req_i.symbol;
            node_wgt[n_loaded] = NWGT_W'(req_i.weight);
            n_loaded++;
          end
          if (req_i.last_entry) begin
            build_codes();
            code_q.push_back('{code: '0, len: '0, status: ST_OK});
          end
        end else begin
          want = '{code: '0, len: '0, status: ST_OK};
          if (!table_ok) want.status = ST_NO_TABLE;
          else if (!present[req_i.symbol]) want.status = ST_UNKNOWN;
          else begin
            want.code = tab_code[req_i.symbol];
            want.len = tab_len[req_i.symbol];
          end
          code_q.push_back(want);
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (code_q.size() == 0) begin
          $display("%0t: unexpected result beat code=%h len=%0d status=%0d", $time,
                   res_i.code_bits, res_i.code_length, res_i.status);
          errors_o++;
        end else begin
          want = code_q.pop_front();
          if (res_i.code_bits !== want.code) begin
            $display("%0t: code_bits expected %h actual %h", $time, want.code,
                     res_i.code_bits);
            errors_o++;
          end
          if (res_i.code_length !== want.len) begin
            $display("%0t: code_length expected %0d actual %0d", $time, want.len,
                     res_i.code_length);
            errors_o++;
          end
          if (res_i.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     res_i.status);
            errors_o++;
          end
        end
      end
      pending_o = code_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import hce_pkg::*;

  localparam int CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   cycles = 0;
  bit   calm_send = 0;
  bit   calm_recv = 0;
  int   n_items = 0;

  hce_in_if  req_if ();
  hce_out_if res_if ();

  huffman_code_build_and_encode_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  hce_scoreboard checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .res_i     (res_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    res_if.ready <= calm_recv || ($urandom_range(99) >= 26);
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold valid across back-to-back beats; drop it only for an idle gap.
  task automatic send_beat(logic rt, logic [SYM_W-1:0] sym, logic [WGT_W-1:0] w,
                           logic lst);
    while (!calm_send && $urandom_range(99) < 26) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= rt;
    req_if.symbol <= sym;
    req_if.weight <= w;
    req_if.last_entry <= lst;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_items++;
  endtask

  task automatic load_set(int n, int mode);
    logic [WGT_W-1:0] w, fa, fb;
    logic [SYM_W-1:0] sym;
    fa = 1;
    fb = 1;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = WGT_W'($urandom);
        1: w = WGT_W'($urandom_range(3));
        2: begin
          w = fa;
          fa = fb;
          fb = (17'(fb) + 17'(w) > 17'h0ffff) ? 16'hffff : fb + w;
        end
        default: w = $urandom_range(1) ? 16'hffff : 16'h0000;
      endcase
      sym = ($urandom_range(9) == 0) ? SYM_W'($urandom_range(7)) : SYM_W'($urandom);
      send_beat(REQ_LOAD, sym, w, i == n - 1);
    end
  endtask

  initial begin
    int n, mode;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_LOAD;
    req_if.symbol = '0;
    req_if.weight = '0;
    req_if.last_entry = 1'b0;
    res_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encode with no table, then a lone symbol with a zero-length code.
    send_beat(REQ_ENCODE, 8'h00, 16'hffff, 1'b1);
    send_beat(REQ_LOAD, 8'hff, 16'hffff, 1'b1);
    send_beat(REQ_ENCODE, 8'hff, 16'h0000, 1'b0);
    send_beat(REQ_ENCODE, 8'h00, 16'h0000, 1'b0);
    // Equal weights and a repeated symbol.
    send_beat(REQ_LOAD, 8'h41, 16'h0000, 1'b0);
    send_beat(REQ_LOAD, 8'h42, 16'h0000, 1'b0);
    send_beat(REQ_LOAD, 8'h41, 16'h0000, 1'b1);
    send_beat(REQ_ENCODE, 8'h41, 16'h0000, 1'b0);
    send_beat(REQ_ENCODE, 8'h42, 16'h0000, 1'b1);
    // Extreme weights; an encode in the middle of a load sees no table.
    send_beat(REQ_LOAD, 8'h01, 16'hffff, 1'b0);
    send_beat(REQ_ENCODE, 8'h01, 16'hffff, 1'b0);
    send_beat(REQ_LOAD, 8'h02, 16'h0000, 1'b0);
    send_beat(REQ_LOAD, 8'h80, 16'hffff, 1'b1);
    send_beat(REQ_ENCODE, 8'h02, 16'h0000, 1'b0);
    send_beat(REQ_ENCODE, 8'h80, 16'h0000, 1'b0);
    send_beat(REQ_ENCODE, 8'h7f, 16'h0000, 1'b0);

    while (pending != 0) @(posedge clk_i);

    // Overfull load: the dropped entries include the one with the last mark.
    for (int i = 0; i < 66; i++)
      send_beat(REQ_LOAD, SYM_W'(i * 3), WGT_W'($urandom), i == 65);
    send_beat(REQ_ENCODE, 8'd189, 16'h0000, 1'b0);
    send_beat(REQ_ENCODE, 8'd195, 16'h0000, 1'b0);
    // Fibonacci weights for a deep tree.
    load_set(24, 2);
    send_beat(REQ_ENCODE, 8'h00, 16'h0000, 1'b0);

    while (n_items < 1100) begin
      calm_send = (n_items > 500 && n_items < 650);
      calm_recv = calm_send;
      case ($urandom_range(49))
        0: n = $urandom_range(60, 70);
        1, 2, 3, 4: n = $urandom_range(9, 40);
        default: n = $urandom_range(1, 8);
      endcase
      mode = $urandom_range(3);
      load_set(n, mode);
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(2) == 0)
          send_beat(REQ_ENCODE, SYM_W'($urandom), WGT_W'($urandom), 1'($urandom));
        else
          send_beat(REQ_ENCODE, SYM_W'($urandom_range(7)), WGT_W'($urandom), 1'($urandom));
      end
    end
    req_if.valid <= 1'b0;
    calm_recv = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
